@@ sv/ltc_pkg.sv @@
// Shared types, constants and helpers for the LTC edge decoder.
// No dependencies; imported by every module of the block.
package ltc_pkg;

    localparam int unsigned IntervalW = 16;
    localparam int unsigned PosW      = 7;
    localparam int unsigned RunW      = 4;
    localparam int unsigned CountW    = 8;
    localparam int unsigned CfgIdxW   = 2;

    localparam logic [IntervalW-1:0] ShortMinReset = 16'd150;
    localparam logic [IntervalW-1:0] LongMinReset  = 16'd380;
    localparam logic [IntervalW-1:0] LongMaxReset  = 16'd600;

    localparam logic [PosW-1:0]   LastDataPos = 7'd63;
    localparam logic [PosW-1:0]   SyncEndPos  = 7'd77;
    localparam logic [PosW-1:0]   FrameEndPos = 7'd80;
    localparam logic [RunW-1:0]   SyncOnes    = 4'd12;
    localparam logic [CountW-1:0] CountMax    = 8'hFF;

    // Configuration register indexes.
    localparam logic [CfgIdxW-1:0] CFG_SHORT_MIN = 2'd0;
    localparam logic [CfgIdxW-1:0] CFG_LONG_MIN  = 2'd1;
    localparam logic [CfgIdxW-1:0] CFG_LONG_MAX  = 2'd2;

    // Input item kinds.
    localparam logic KIND_EDGE = 1'b0;
    localparam logic KIND_TICK = 1'b1;

    // Rate type codes.
    localparam logic [1:0] RATE_FILM = 2'd0;
    localparam logic [1:0] RATE_EBU  = 2'd1;
    localparam logic [1:0] RATE_DROP = 2'd2;
    localparam logic [1:0] RATE_SMPTE = 2'd3;

    typedef struct packed {
        logic [5:0] frames;
        logic [6:0] seconds;
        logic [6:0] minutes;
        logic [5:0] hours;
        logic       drop_frame;
        logic [1:0] rate_type;
    } ltc_result_t;

    typedef struct packed {
        logic        valid;
        ltc_result_t data;
    } ltc_result_beat_t;

    // Two BCD digits to binary: tens * 10 + units.
    function automatic logic [6:0] bcd2bin(input logic [2:0] tens, input logic [3:0] units);
        logic [6:0] t8;
        logic [6:0] t2;
        t8 = {1'b0, tens, 3'b000};
        t2 = {3'b000, tens, 1'b0};
        return t8 + t2 + {3'b000, units};
    endfunction

endpackage

@@ sv/ltc_decoder.sv @@
// Biphase-mark bit slicer, frame assembler and per-second frame counter.
// Holds the configuration registers. Depends on ltc_pkg.
module ltc_decoder
    import ltc_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_we,
    input  logic [CfgIdxW-1:0]   cfg_index,
    input  logic [IntervalW-1:0] cfg_wdata,
    input  logic                 beat_accept,
    input  logic                 kind,
    input  logic [IntervalW-1:0] edge_interval,
    output ltc_result_beat_t     result
);

    logic [IntervalW-1:0] short_min_reg, long_min_reg, long_max_reg;
    logic [63:0]          frame_bits_reg, frame_bits_next;
    logic [PosW-1:0]      bit_position_reg, bit_position_next;
    logic [RunW-1:0]      ones_run_reg, ones_run_next;
    logic                 half_one_seen_reg, half_one_seen_next;
    logic                 sync_seen_reg, sync_seen_next;
    logic [CountW-1:0]    frames_this_reg, frames_this_next;
    logic [CountW-1:0]    frames_last_reg, frames_last_next;

    logic            frame_done;
    logic [PosW-1:0] pos;
    logic [RunW-1:0] run_inc;
    logic            bit_val;
    logic            df;
    logic            rate_ok;
    logic [1:0]      rate;

    always_comb begin
        frame_bits_next    = frame_bits_reg;
        bit_position_next  = bit_position_reg;
        ones_run_next      = ones_run_reg;
        half_one_seen_next = half_one_seen_reg;
        sync_seen_next     = sync_seen_reg;
        frames_this_next   = frames_this_reg;
        frames_last_next   = frames_last_reg;
        frame_done         = 1'b0;
        pos                = bit_position_reg;
        run_inc            = ones_run_reg + 4'd1;
        bit_val            = (edge_interval <= long_min_reg);

        if (beat_accept) begin
            if (kind == KIND_TICK) begin
                frames_last_next = frames_this_reg;
                frames_this_next = '0;
            end else if (edge_interval < short_min_reg || edge_interval > long_max_reg) begin
                bit_position_next = '0;
            end else begin
                if (half_one_seen_reg) begin
                    half_one_seen_next = 1'b0;
                end else begin
                    if (!bit_val) begin
                        ones_run_next = '0;
                    end else begin
                        half_one_seen_next = 1'b1;
                        if (run_inc == SyncOnes) begin
                            ones_run_next  = '0;
                            sync_seen_next = 1'b1;
                            pos            = SyncEndPos;
                        end else begin
                            ones_run_next = run_inc;
                        end
                    end
                    if (pos <= LastDataPos) begin
                        frame_bits_next = {bit_val, frame_bits_reg[63:1]};
                    end
                    pos = pos + 7'd1;
                end
                bit_position_next = pos;
                if (pos == FrameEndPos) begin
                    bit_position_next = '0;
                    if (sync_seen_next) begin
                        sync_seen_next = 1'b0;
                        frame_done     = 1'b1;
                    end
                end
                if (frame_done && frames_this_reg != CountMax) begin
                    frames_this_next = frames_this_reg + 8'd1;
                end
            end
        end
    end

    // A finished frame never shifts on its last edge, so the stored word is final.
    always_comb begin
        df      = frame_bits_reg[10];
        rate_ok = 1'b1;
        if (df) begin
            rate = RATE_DROP;
        end else if (frames_last_reg <= 8'd24) begin
            rate = RATE_FILM;
        end else if (frames_last_reg <= 8'd26) begin
            rate = RATE_EBU;
        end else if (frames_last_reg >= 8'd28) begin
            rate = RATE_SMPTE;
        end else begin
            rate    = RATE_SMPTE;
            rate_ok = 1'b0;
        end
        result.valid           = frame_done && rate_ok;
        result.data.frames     = 6'(bcd2bin({1'b0, frame_bits_reg[9:8]}, frame_bits_reg[3:0]));
        result.data.seconds    = bcd2bin(frame_bits_reg[26:24], frame_bits_reg[19:16]);
        result.data.minutes    = bcd2bin(frame_bits_reg[42:40], frame_bits_reg[35:32]);
        result.data.hours      = 6'(bcd2bin({1'b0, frame_bits_reg[57:56]}, frame_bits_reg[51:48]));
        result.data.drop_frame = df;
        result.data.rate_type  = rate;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            short_min_reg     <= ShortMinReset;
            long_min_reg      <= LongMinReset;
            long_max_reg      <= LongMaxReset;
            frame_bits_reg    <= '0;
            bit_position_reg  <= '0;
            ones_run_reg      <= '0;
            half_one_seen_reg <= 1'b0;
            sync_seen_reg     <= 1'b0;
            frames_this_reg   <= '0;
            frames_last_reg   <= '0;
        end else begin
            if (cfg_we) begin
                unique case (cfg_index)
                    CFG_SHORT_MIN: short_min_reg <= cfg_wdata;
                    CFG_LONG_MIN:  long_min_reg  <= cfg_wdata;
                    CFG_LONG_MAX:  long_max_reg  <= cfg_wdata;
                    default: ;
                endcase
            end
            frame_bits_reg    <= frame_bits_next;
            bit_position_reg  <= bit_position_next;
            ones_run_reg      <= ones_run_next;
            half_one_seen_reg <= half_one_seen_next;
            sync_seen_reg     <= sync_seen_next;
            frames_this_reg   <= frames_this_next;
            frames_last_reg   <= frames_last_next;
        end
    end

endmodule

@@ sv/ltc_outbuf.sv @@
// Result register with a skid stage so the input side keeps flowing
// while a result waits. Depends on ltc_pkg.
module ltc_outbuf
    import ltc_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  ltc_result_beat_t push,
    output logic             in_ready,
    output logic             out_valid,
    input  logic             out_ready,
    output ltc_result_t      out_data
);

    logic        main_valid_reg, main_valid_next;
    logic        skid_valid_reg, skid_valid_next;
    ltc_result_t main_reg, main_next;
    ltc_result_t skid_reg, skid_next;
    logic        pop;

    assign pop       = main_valid_reg && out_ready;
    assign in_ready  = !skid_valid_reg;
    assign out_valid = main_valid_reg;
    assign out_data  = main_reg;

    always_comb begin
        main_valid_next = main_valid_reg;
        skid_valid_next = skid_valid_reg;
        main_next       = main_reg;
        skid_next       = skid_reg;
        if (skid_valid_reg) begin
            // No new beat is taken while the skid stage is full.
            if (pop) begin
                main_next       = skid_reg;
                skid_valid_next = 1'b0;
            end
        end else if (push.valid) begin
            if (!main_valid_reg || pop) begin
                main_next       = push.data;
                main_valid_next = 1'b1;
            end else begin
                skid_next       = push.data;
                skid_valid_next = 1'b1;
            end
        end else if (pop) begin
            main_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
        main_reg <= main_next;
        skid_reg <= skid_next;
    end

endmodule

@@ sv/ltc_timecode_edge_decoder.sv @@
// The edge beat that ends a frame has its result registered before it shows on m_valid;
// it waits in the skid stage while an earlier result is still waiting for m_ready.
// Throughput: one input beat per cycle; the decoder state updates in the accepting cycle.
// s_ready drops only while both the result register and its skid stage hold results.
// Reset (aresetn low, synchronous) sets default thresholds, clears all but result data.
module ltc_timecode_edge_decoder
    import ltc_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_we,
    input  logic [CfgIdxW-1:0]   cfg_index,
    input  logic [IntervalW-1:0] cfg_wdata,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic                 s_kind,
    input  logic [IntervalW-1:0] s_edge_interval,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [5:0]           m_frames,
    output logic [6:0]           m_seconds,
    output logic [6:0]           m_minutes,
    output logic [5:0]           m_hours,
    output logic                 m_drop_frame,
    output logic [1:0]           m_rate_type
);

    ltc_result_beat_t result;
    ltc_result_t      out_data;
    logic             beat_accept;

    assign beat_accept = s_valid && s_ready;

    ltc_decoder u_decoder (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .beat_accept   (beat_accept),
        .kind          (s_kind),
        .edge_interval (s_edge_interval),
        .result        (result)
    );

    ltc_outbuf u_outbuf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (result),
        .in_ready  (s_ready),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_data  (out_data)
    );

    assign m_frames     = out_data.frames;
    assign m_seconds    = out_data.seconds;
    assign m_minutes    = out_data.minutes;
    assign m_hours      = out_data.hours;
    assign m_drop_frame = out_data.drop_frame;
    assign m_rate_type  = out_data.rate_type;

endmodule

@@ sv/ltc_checker.sv @@
// Port-level checks for the LTC edge decoder, attached by bind.
// Depends on ltc_pkg and ltc_timecode_edge_decoder.
module ltc_checker
    import ltc_pkg::*;
(
    input logic       aclk,
    input logic       aresetn,
    input logic       m_valid,
    input logic       m_ready,
    input logic [5:0] m_frames,
    input logic [1:0] m_rate_type,
    input logic       m_drop_frame
);

    // A stalled result holds its value.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_frames) && $stable(m_rate_type))
        else $error("stalled result changed");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result present right after reset");

    a_df_rate: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_drop_frame |-> m_rate_type == RATE_DROP)
        else $error("drop-frame result without drop rate type");

    a_rate_df: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_drop_frame |-> m_rate_type != RATE_DROP)
        else $error("drop rate type without drop-frame flag");

    a_frames_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_frames <= 6'd45)
        else $error("frame number out of range");

endmodule

bind ltc_timecode_edge_decoder ltc_checker u_ltc_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_frames     (m_frames),
    .m_rate_type  (m_rate_type),
    .m_drop_frame (m_drop_frame)
);

@@ tb/tb_ltc_timecode_edge_decoder.sv @@
// Self-checking testbench for the LTC timecode edge decoder.
// Drives edge intervals and second ticks and checks each timecode against a local decoder model.
// Depends on ltc_pkg and ltc_timecode_edge_decoder.
module tb_ltc_timecode_edge_decoder;
    timeunit 1ns;
    timeprecision 1ps;
    import ltc_pkg::*;

    localparam int RESET_CYCLES    = 12;
    localparam int SETTLE_CYCLES   = 8;
    localparam int QUIET_LIMIT     = 2000;
    localparam int FILM_MAX_FPS    = 24;
    localparam int EBU_MAX_FPS     = 26;
    localparam int SMPTE_MIN_FPS   = 28;

    // Index with no register behind it; writes to it must be ignored.
    localparam logic [CfgIdxW-1:0] CFG_SPARE = 2'd3;

    typedef struct packed {
        logic                 kind;
        logic [IntervalW-1:0] interval;
    } edge_item_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 cfg_we = 1'b0;
    logic [CfgIdxW-1:0]   cfg_index = '0;
    logic [IntervalW-1:0] cfg_wdata = '0;
    logic                 s_valid = 1'b0;
    logic                 s_ready;
    logic                 s_kind = KIND_EDGE;
    logic [IntervalW-1:0] s_edge_interval = '0;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    logic [5:0]           m_frames;
    logic [6:0]           m_seconds;
    logic [6:0]           m_minutes;
    logic [5:0]           m_hours;
    logic                 m_drop_frame;
    logic [1:0]           m_rate_type;

    ltc_timecode_edge_decoder dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_kind         (s_kind),
        .s_edge_interval(s_edge_interval),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_frames       (m_frames),
        .m_seconds      (m_seconds),
        .m_minutes      (m_minutes),
        .m_hours        (m_hours),
        .m_drop_frame   (m_drop_frame),
        .m_rate_type    (m_rate_type)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // Thresholds as the decoder currently holds them.
    logic [IntervalW-1:0] thr_short_min = ShortMinReset;
    logic [IntervalW-1:0] thr_long_min  = LongMinReset;
    logic [IntervalW-1:0] thr_long_max  = LongMaxReset;

    // Decoder state mirror.
    logic [63:0]       frame_sr = '0;
    logic [PosW-1:0]   bit_pos = '0;
    logic [RunW-1:0]   one_run = '0;
    logic              mid_one = 1'b0;
    logic              sync_armed = 1'b0;
    logic [CountW-1:0] frames_now = '0;
    logic [CountW-1:0] frames_prev = '0;

    edge_item_t  stimulus_q[$];
    ltc_result_t timecode_q[$];
    edge_item_t  next_item;
    ltc_result_t predicted_tc;
    ltc_result_t got_tc;

    int edge_beats = 0;
    int tick_beats = 0;
    int timecodes_checked = 0;
    int withheld_frames = 0;
    int rate_seen[4] = '{0, 0, 0, 0};
    int mismatches = 0;

    // Returns 1 when the beat completes a timecode that the block reports.
    function automatic bit decode_beat(input logic kind, input logic [IntervalW-1:0] iv,
                                       output ltc_result_t tc);
        bit         data_bit;
        bit         frame_done;
        bit         df;
        logic [1:0] rate;
        tc = '0;
        frame_done = 1'b0;
        if (kind == KIND_TICK) begin
            frames_prev = frames_now;
            frames_now = '0;
            return 1'b0;
        end
        if (iv < thr_short_min || iv > thr_long_max) begin
            bit_pos = '0;
            return 1'b0;
        end
        if (mid_one) begin
            mid_one = 1'b0;
        end else begin
            if (iv > thr_long_min) begin
                data_bit = 1'b0;
                one_run = '0;
            end else begin
                data_bit = 1'b1;
                mid_one = 1'b1;
                one_run = one_run + 1'b1;
                if (one_run == SyncOnes) begin
                    one_run = '0;
                    sync_armed = 1'b1;
                    bit_pos = SyncEndPos;
                end
            end
            if (bit_pos <= LastDataPos) begin
                frame_sr = {data_bit, frame_sr[63:1]};
            end
            bit_pos = bit_pos + 1'b1;
        end
        if (bit_pos == FrameEndPos) begin
            bit_pos = '0;
            if (sync_armed) begin
                sync_armed = 1'b0;
                frame_done = 1'b1;
            end
        end
        if (!frame_done) begin
            return 1'b0;
        end
        if (frames_now != CountMax) begin
            frames_now = frames_now + 1'b1;
        end
        df = frame_sr[10];
        if (df) begin
            rate = RATE_DROP;
        end else if (frames_prev <= FILM_MAX_FPS) begin
            rate = RATE_FILM;
        end else if (frames_prev <= EBU_MAX_FPS) begin
            rate = RATE_EBU;
        end else if (frames_prev >= SMPTE_MIN_FPS) begin
            rate = RATE_SMPTE;
        end else begin
            // 27 frames per second cannot be told apart, so the frame is not reported.
            withheld_frames++;
            return 1'b0;
        end
        rate_seen[rate]++;
        tc.frames     = 6'(10 * frame_sr[9:8] + frame_sr[3:0]);
        tc.seconds    = 7'(10 * frame_sr[26:24] + frame_sr[19:16]);
        tc.minutes    = 7'(10 * frame_sr[42:40] + frame_sr[35:32]);
        tc.hours      = 6'(10 * frame_sr[57:56] + frame_sr[51:48]);
        tc.drop_frame = df;
        tc.rate_type  = rate;
        return 1'b1;
    endfunction

    function automatic void push_edge(input logic [IntervalW-1:0] iv);
        stimulus_q.push_back('{KIND_EDGE, iv});
    endfunction

    function automatic void push_tick();
        stimulus_q.push_back('{KIND_TICK, IntervalW'($urandom)});
    endfunction

    // One biphase-mark bit at the current thresholds.
    function automatic void push_bit(input bit b);
        if (b) begin
            push_edge(IntervalW'($urandom_range(thr_long_min, thr_short_min)));
            push_edge(IntervalW'($urandom_range(thr_long_max, thr_short_min)));
        end else begin
            push_edge(IntervalW'($urandom_range(thr_long_max, thr_long_min + 1)));
        end
    endfunction

    function automatic void push_noise(input int n);
        logic [IntervalW-1:0] iv;
        for (int i = 0; i < n; i++) begin
            case ($urandom_range(9))
                0: begin
                    push_tick();
                    continue;
                end
                1, 2, 3, 4: begin
                    case ($urandom_range(7))
                        0: iv = '0;
                        1: iv = '1;
                        2: iv = thr_short_min - 1'b1;
                        3: iv = thr_short_min;
                        4: iv = thr_long_min;
                        5: iv = thr_long_min + 1'b1;
                        6: iv = thr_long_max;
                        default: iv = thr_long_max + 1'b1;
                    endcase
                end
                5, 6, 7: iv = IntervalW'($urandom);
                default: iv = IntervalW'($urandom_range(thr_long_max, thr_short_min));
            endcase
            push_edge(iv);
        end
    endfunction

    // A full frame carries 64 random data bits; a short one only a few before the sync run.
    function automatic void push_frame(input bit full);
        logic [63:0] data;
        int          n;
        if (full) begin
            data = {$urandom, $urandom};
            for (int i = 0; i < 64; i++) begin
                push_bit(data[i]);
            end
            push_bit(1'b0);
        end else begin
            // Mostly zero data keeps the drop-frame bit clear often enough.
            n = $urandom_range(9, 2);
            for (int i = 0; i < n; i++) begin
                push_bit($urandom_range(3) == 0);
            end
        end
        push_bit(1'b0);
        repeat (12) push_bit(1'b1);
        push_bit(1'b0);
        push_bit(1'b1);
    endfunction

    // Frames of one second followed by its tick, then some noise and at times a broken sync run.
    function automatic void push_second(input int n);
        for (int i = 0; i < n; i++) begin
            push_frame($urandom_range(5) == 0);
            if ($urandom_range(15) == 0) begin
                push_noise($urandom_range(3, 1));
            end
        end
        push_tick();
        push_noise($urandom_range(4));
        if ($urandom_range(3) == 0) begin
            repeat ($urandom_range(11, 4)) push_bit(1'b1);
            push_noise(1);
        end
    endfunction

    // A second packed with bare sync runs, so the next second sees a high frame count.
    function automatic void push_dense_second(input int n);
        for (int i = 0; i < n; i++) begin
            repeat (12) push_bit(1'b1);
            push_bit(1'b0);
            push_bit(1'b0);
        end
        push_tick();
    endfunction

    task automatic wait_idle();
        while (stimulus_q.size() != 0 || s_valid || timecode_q.size() != 0) begin
            @(negedge aclk);
        end
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    // Called at a falling edge; raises the write enable and leaves it high for the caller to drop.
    task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [IntervalW-1:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(negedge aclk);
    endtask

    task automatic set_thresholds(input logic [IntervalW-1:0] short_min,
                                  input logic [IntervalW-1:0] long_min,
                                  input logic [IntervalW-1:0] long_max);
        write_reg(CFG_SHORT_MIN, short_min);
        write_reg(CFG_LONG_MIN, long_min);
        write_reg(CFG_LONG_MAX, long_max);
        write_reg(CFG_SPARE, IntervalW'($urandom));
        cfg_we <= 1'b0;
        thr_short_min = short_min;
        thr_long_min = long_min;
        thr_long_max = long_max;
    endtask

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            mismatches++;
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
        end
    endtask

    // Sender: bursts of beats separated by random gaps.
    int  burst_left = 0;
    int  gap_left = 0;
    logic in_taken = 1'b0;

    always @(negedge aclk) begin
        if (aresetn && (!s_valid || in_taken)) begin
            if (gap_left != 0) begin
                gap_left--;
                s_valid <= 1'b0;
            end else if (stimulus_q.size() != 0) begin
                next_item = stimulus_q.pop_front();
                s_valid <= 1'b1;
                s_kind <= next_item.kind;
                s_edge_interval <= next_item.interval;
                if (burst_left <= 1) begin
                    burst_left = $urandom_range(40, 1);
                    gap_left = ($urandom_range(2) == 0) ? 0 : $urandom_range(12, 1);
                end else begin
                    burst_left--;
                end
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Receiver: ready follows a rotating pattern that is redrawn whenever its countdown runs out.
    logic [31:0] stall_pattern = '1;
    int          stall_left = 0;

    always @(negedge aclk) begin
        if (stall_left == 0) begin
            case ($urandom_range(3))
                0: stall_pattern = '1;
                1: stall_pattern = $urandom | 32'h1111_1111;
                2: stall_pattern = $urandom | 32'h0101_0101;
                default: stall_pattern = $urandom | 32'h8080_8080;
            endcase
            stall_left = 64;
        end
        m_ready <= stall_pattern[0];
        stall_pattern = {stall_pattern[0], stall_pattern[31:1]};
        stall_left--;
    end

    // Monitor: predicts on every input beat and checks every result beat.
    always @(posedge aclk) begin
        in_taken <= s_valid && s_ready;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                if (s_kind == KIND_TICK) begin
                    tick_beats++;
                end else begin
                    edge_beats++;
                end
                if (decode_beat(s_kind, s_edge_interval, predicted_tc)) begin
                    timecode_q.push_back(predicted_tc);
                end
            end
            if (m_valid && m_ready) begin
                if (timecode_q.size() == 0) begin
                    mismatches++;
                    $display("%0t: result beat with none expected, got %0d:%0d:%0d:%0d rate %0d",
                             $time, m_hours, m_minutes, m_seconds, m_frames, m_rate_type);
                end else begin
                    got_tc = timecode_q.pop_front();
                    timecodes_checked++;
                    check_field("frames", got_tc.frames, m_frames);
                    check_field("seconds", got_tc.seconds, m_seconds);
                    check_field("minutes", got_tc.minutes, m_minutes);
                    check_field("hours", got_tc.hours, m_hours);
                    check_field("drop_frame", got_tc.drop_frame, m_drop_frame);
                    check_field("rate_type", got_tc.rate_type, m_rate_type);
                end
            end
        end
    end

    int quiet_cycles = 0;

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) || cfg_we) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles == QUIET_LIMIT) begin
            $display("%0t: no beat moved for %0d cycles, %0d timecodes still expected",
                     $time, QUIET_LIMIT, timecode_q.size());
            $display("tb_ltc_timecode_edge_decoder NOT OK");
            $finish;
        end
    end

    initial begin
        repeat (RESET_CYCLES) @(negedge aclk);
        aresetn <= 1'b1;

        // Window edges, halves of a one split by a rejected interval, and ticks.
        push_tick();
        push_edge('0);
        push_edge('1);
        push_edge(thr_short_min - 1'b1);
        push_edge(thr_short_min);
        push_edge(thr_long_max);
        push_edge(thr_long_max + 1'b1);
        push_edge(thr_long_min);
        push_edge(thr_long_max + 1'b1);
        push_edge(thr_long_min + 1'b1);
        push_edge(thr_long_min + 1'b1);
        push_edge(thr_long_max);
        push_edge(thr_short_min);
        push_edge(thr_short_min);
        push_tick();

        push_second(1);
        // A busy second of 25 to 28 frames sets the rate seen by the frames after it.
        push_dense_second($urandom_range(28, 25));
        push_second(2);
        wait_idle();

        set_thresholds(16'd0, 16'd0, 16'hFFFF);
        push_second(1);
        wait_idle();

        set_thresholds(16'd0, 16'hFFFE, 16'hFFFF);
        push_second(1);
        wait_idle();

        // Only the largest interval is accepted, and it counts as short.
        set_thresholds(16'hFFFF, 16'hFFFF, 16'hFFFF);
        repeat (26) push_edge('1);
        push_noise(8);
        wait_idle();

        set_thresholds(16'd0, 16'd0, 16'd0);
        repeat (26) push_edge('0);
        push_noise(8);
        wait_idle();

        // Window is empty, so every interval is rejected.
        set_thresholds(16'd500, 16'd400, 16'd300);
        push_noise(20);
        wait_idle();

        set_thresholds(16'd100, 16'd200, 16'd300);
        push_second(1);
        wait_idle();

        set_thresholds(ShortMinReset, LongMinReset, LongMaxReset);
        push_second(1);
        wait_idle();

        $display("Sent %0d edge beats and %0d second ticks across eight threshold settings.",
                 edge_beats, tick_beats);
        $display("Checked %0d timecodes: film %0d, EBU %0d, drop %0d, SMPTE %0d; %0d withheld.",
                 timecodes_checked, rate_seen[RATE_FILM], rate_seen[RATE_EBU],
                 rate_seen[RATE_DROP], rate_seen[RATE_SMPTE], withheld_frames);
        if (mismatches == 0) begin
            $display("tb_ltc_timecode_edge_decoder OK");
        end else begin
            $display("tb_ltc_timecode_edge_decoder NOT OK");
        end
        $finish;
    end

endmodule
